FILE: hdl/polrs_pkg.sv
// Package with the word types, the command type, the sequencer states and constants.
`default_nettype none
package polrs_pkg;
   localparam int MAX_STEPS = 63;
   localparam int COORD_W = 32;
   localparam int HEAD_W = 16;
   localparam int RES_W = 24;
   localparam int DX_W = COORD_W + 1;
   localparam int N_W = $clog2(MAX_STEPS + 1);
   localparam int K_W = $clog2(MAX_STEPS + 2);
   localparam int M_W = RES_W + K_W;
   localparam int SQ_W = 2 * M_W;
   localparam int SUM_W = 2 * COORD_W + 1;
   localparam int MUL_W = COORD_W;
   localparam int DIVC_W = $clog2(DX_W);
   localparam logic [RES_W-1:0] RES_RESET = RES_W'(256);
   localparam logic [K_W-1:0] K_LIMIT = K_W'(MAX_STEPS + 1);
   localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(DX_W - 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] way_x;
      logic signed [COORD_W-1:0] way_y;
      logic [HEAD_W-1:0] way_heading;
      logic path_end;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pt_x;
      logic signed [COORD_W-1:0] pt_y;
      logic [HEAD_W-1:0] pt_heading;
      logic run_last;
      logic path_done;
      logic count_clipped;
   } rsp_word_type;

   typedef struct packed {
      logic has_seg;
      logic seg_end;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [HEAD_W-1:0] sh;
      logic signed [DX_W-1:0] dx;
      logic signed [DX_W-1:0] dy;
      logic [COORD_W-1:0] ex;
      logic [COORD_W-1:0] ey;
      logic [HEAD_W-1:0] eh;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQX, ST_SQY, ST_MUL, ST_CMP, ST_PREP,
      ST_DIVX, ST_DIVY, ST_EMIT, ST_END
   } back_state_type;
endpackage
`default_nettype wire

FILE: hdl/polrs_front.sv
// Front part: accepts waypoints, keeps the previous one and builds segment commands.
`default_nettype none
module polrs_front
   import polrs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_push,
   input  wire req_word_type req_word,
   input  wire logic cmd_full,
   output logic cmd_push,
   output cmd_type cmd_word
);
   logic have_prev_ff, have_prev_in;
   logic [COORD_W-1:0] prev_x_ff, prev_y_ff, prev_x_in, prev_y_in;
   logic [HEAD_W-1:0] prev_h_ff, prev_h_in;
   logic accept;

   always_comb begin
      accept = req_push && !cmd_full;
      have_prev_in = have_prev_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      prev_h_in = prev_h_ff;
      if (accept) begin
         if (req_word.path_end) begin
            have_prev_in = 1'b0;
         end else begin
            have_prev_in = 1'b1;
            prev_x_in = req_word.way_x;
            prev_y_in = req_word.way_y;
            prev_h_in = req_word.way_heading;
         end
      end
      cmd_push = accept && (have_prev_ff || req_word.path_end);
      cmd_word.has_seg = have_prev_ff;
      cmd_word.seg_end = req_word.path_end;
      cmd_word.sx = prev_x_ff;
      cmd_word.sy = prev_y_ff;
      cmd_word.sh = prev_h_ff;
      cmd_word.dx = DX_W'(req_word.way_x) - DX_W'(signed'(prev_x_ff));
      cmd_word.dy = DX_W'(req_word.way_y) - DX_W'(signed'(prev_y_ff));
      cmd_word.ex = req_word.way_x;
      cmd_word.ey = req_word.way_y;
      cmd_word.eh = req_word.way_heading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_h_ff <= '0;
      end else begin
         have_prev_ff <= have_prev_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         prev_h_ff <= prev_h_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/polrs_cmd_fifo.sv
// Two-entry command queue between the front and back parts.
`default_nettype none
module polrs_cmd_fifo
   import polrs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire cmd_type push_word,
   output logic full,
   input  wire logic pop,
   output logic empty,
   output cmd_type head_word
);
   cmd_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head_word = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end
endmodule
`default_nettype wire

FILE: hdl/polrs_back.sv
// Back part: segment length count, per-axis division and point generation.
`default_nettype none
module polrs_back
   import polrs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic [RES_W-1:0] csr_wdata,
   input  wire logic cmd_empty,
   input  wire cmd_type cmd_head,
   output logic cmd_pop,
   output logic rsp_empty,
   input  wire logic rsp_pop,
   output rsp_word_type rsp_word
);
   back_state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [RES_W-1:0] res_ff, res_eff;
   logic [SUM_W-1:0] s_ff, s_in;
   logic [M_W-1:0] m_ff, m_in;
   logic [SQ_W-1:0] sq_ff, sq_in;
   logic [K_W-1:0] k_ff, k_in;
   logic [N_W-1:0] n_ff, n_in, j_ff, j_in;
   logic clip_ff, clip_in;
   logic [DIVC_W-1:0] dcnt_ff, dcnt_in;
   logic [DX_W-1:0] dsh_ff, dsh_in, dq_ff, dq_in;
   logic [N_W-1:0] drem_ff, drem_in;
   logic [DX_W-1:0] qx_ff, qx_in, qy_ff, qy_in, ax_q_ff, ax_q_in, ay_q_ff, ay_q_in;
   logic [N_W-1:0] rx_ff, rx_in, ry_ff, ry_in, ax_r_ff, ax_r_in, ay_r_ff, ay_r_in;
   rsp_word_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;
   logic [DX_W-1:0] ax, ay, offx, offy;
   logic [MUL_W-1:0] mul_a;
   logic [2*MUL_W-1:0] prod;
   logic [N_W:0] rem_t, sx_t, sy_t;
   logic out_free, last_pt;

   assign res_eff = (res_ff == '0) ? RES_W'(1) : res_ff;
   assign rsp_empty = !out_valid_ff;
   assign rsp_word = out_ff;

   always_comb begin
      ax = cmd_ff.dx[DX_W-1] ? DX_W'(-cmd_ff.dx) : DX_W'(cmd_ff.dx);
      ay = cmd_ff.dy[DX_W-1] ? DX_W'(-cmd_ff.dy) : DX_W'(cmd_ff.dy);
      case (state_ff)
         ST_SQX: mul_a = ax[MUL_W-1:0];
         ST_SQY: mul_a = ay[MUL_W-1:0];
         default: mul_a = MUL_W'(m_ff);
      endcase
      prod = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_a};
      rem_t = {drem_ff, dsh_ff[DX_W-1]};
      sx_t = {1'b0, ax_r_ff} + {1'b0, rx_ff};
      sy_t = {1'b0, ay_r_ff} + {1'b0, ry_ff};
      offx = cmd_ff.dx[DX_W-1] ? DX_W'(-ax_q_ff) : ax_q_ff;
      offy = cmd_ff.dy[DX_W-1] ? DX_W'(-ay_q_ff) : ay_q_ff;
      out_free = !out_valid_ff || rsp_pop;
      last_pt = (j_ff == n_ff - N_W'(1));
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      s_in = s_ff;
      m_in = m_ff;
      sq_in = sq_ff;
      k_in = k_ff;
      n_in = n_ff;
      j_in = j_ff;
      clip_in = clip_ff;
      dcnt_in = dcnt_ff;
      dsh_in = dsh_ff;
      dq_in = dq_ff;
      drem_in = drem_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      ax_q_in = ax_q_ff;
      ay_q_in = ay_q_ff;
      ax_r_in = ax_r_ff;
      ay_r_in = ay_r_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      cmd_pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cmd_in = cmd_head;
               state_in = cmd_head.has_seg ? ST_SQX : ST_END;
            end
         end
         ST_SQX: begin
            s_in = SUM_W'(prod);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            s_in = s_ff + SUM_W'(prod);
            m_in = M_W'(res_eff);
            k_in = K_W'(1);
            n_in = '0;
            clip_in = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            sq_in = prod[SQ_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (s_ff >= SUM_W'(sq_ff)) begin
               if (k_ff == K_LIMIT) begin
                  clip_in = 1'b1;
                  state_in = ST_PREP;
               end else begin
                  n_in = k_ff[N_W-1:0];
                  k_in = k_ff + K_W'(1);
                  m_in = m_ff + M_W'(res_eff);
                  state_in = ST_MUL;
               end
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            dsh_in = ax;
            drem_in = '0;
            dcnt_in = '0;
            if (n_ff == '0) begin
               state_in = cmd_ff.seg_end ? ST_END : ST_IDLE;
            end else begin
               state_in = ST_DIVX;
            end
         end
         ST_DIVX, ST_DIVY: begin
            if (rem_t >= {1'b0, n_ff}) begin
               drem_in = N_W'(rem_t - {1'b0, n_ff});
               dq_in = {dq_ff[DX_W-2:0], 1'b1};
            end else begin
               drem_in = rem_t[N_W-1:0];
               dq_in = {dq_ff[DX_W-2:0], 1'b0};
            end
            dsh_in = {dsh_ff[DX_W-2:0], 1'b0};
            dcnt_in = dcnt_ff + DIVC_W'(1);
            if (dcnt_ff == DIV_LAST) begin
               dcnt_in = '0;
               if (state_ff == ST_DIVX) begin
                  qx_in = dq_in;
                  rx_in = drem_in;
                  dsh_in = ay;
                  drem_in = '0;
                  state_in = ST_DIVY;
               end else begin
                  qy_in = dq_in;
                  ry_in = drem_in;
                  ax_q_in = '0;
                  ay_q_in = '0;
                  ax_r_in = '0;
                  ay_r_in = '0;
                  j_in = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.pt_x = cmd_ff.sx + offx[COORD_W-1:0];
               out_in.pt_y = cmd_ff.sy + offy[COORD_W-1:0];
               out_in.pt_heading = cmd_ff.sh;
               out_in.run_last = last_pt && !cmd_ff.seg_end;
               out_in.path_done = 1'b0;
               out_in.count_clipped = clip_ff;
               if (sx_t >= {1'b0, n_ff}) begin
                  ax_r_in = N_W'(sx_t - {1'b0, n_ff});
                  ax_q_in = ax_q_ff + qx_ff + DX_W'(1);
               end else begin
                  ax_r_in = sx_t[N_W-1:0];
                  ax_q_in = ax_q_ff + qx_ff;
               end
               if (sy_t >= {1'b0, n_ff}) begin
                  ay_r_in = N_W'(sy_t - {1'b0, n_ff});
                  ay_q_in = ay_q_ff + qy_ff + DX_W'(1);
               end else begin
                  ay_r_in = sy_t[N_W-1:0];
                  ay_q_in = ay_q_ff + qy_ff;
               end
               j_in = j_ff + N_W'(1);
               if (last_pt) begin
                  state_in = cmd_ff.seg_end ? ST_END : ST_IDLE;
               end
            end
         end
         ST_END: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.pt_x = cmd_ff.ex;
               out_in.pt_y = cmd_ff.ey;
               out_in.pt_heading = cmd_ff.eh;
               out_in.run_last = 1'b1;
               out_in.path_done = 1'b1;
               out_in.count_clipped = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         res_ff <= RES_RESET;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            res_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      s_ff <= s_in;
      m_ff <= m_in;
      sq_ff <= sq_in;
      k_ff <= k_in;
      n_ff <= n_in;
      j_ff <= j_in;
      clip_ff <= clip_in;
      dcnt_ff <= dcnt_in;
      dsh_ff <= dsh_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      ax_q_ff <= ax_q_in;
      ay_q_ff <= ay_q_in;
      ax_r_ff <= ax_r_in;
      ay_r_ff <= ay_r_in;
      out_ff <= out_in;
   end
endmodule
`default_nettype wire

FILE: hdl/polyline_resampler_core.sv
// Top level of the polyline resampler: front part, command queue and back part.
// Waypoints enter as words on the req_ queue port (push/full) and generated points
// leave on the rsp_ queue port (empty/pop). The csr_ port sets the point spacing.
// A waypoint is taken in the cycle it is pushed while the two-entry command queue
// has room. Each segment then takes the back part through taking the command,
// the squared length, a multiply and compare per tried point count (n + 1 tries,
// at most 64), a setup step, serial division for the two axes and the generated
// points; a segment with no points skips division and emission. A path end word
// adds an end step that outputs the final waypoint as a path-done word.
// The divider produces one quotient bit per cycle; points leave at one per cycle
// while the output register is free or popped.
// A waypoint with no segment and no path end is only stored by the front part.
// Reset clears the stored previous waypoint, the queue and the output register,
// and sets the spacing to 1.0 meter. When the receiver does not pop, the output
// register holds its word, the back part waits, and full rises once the queue
// has filled.
`default_nettype none
module polyline_resampler_core
   import polrs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_push,
   input  wire req_word_type req_word,
   output logic req_full,
   output logic rsp_empty,
   input  wire logic rsp_pop,
   output rsp_word_type rsp_word,
   input  wire logic csr_we,
   input  wire logic [RES_W-1:0] csr_wdata
);
   logic cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_word, cmd_head;

   assign req_full = cmd_full;

   polrs_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_word(req_word),
      .cmd_full(cmd_full), .cmd_push(cmd_push), .cmd_word(cmd_word)
   );

   polrs_cmd_fifo u_fifo (
      .clock(clock), .reset(reset), .push(cmd_push), .push_word(cmd_word),
      .full(cmd_full), .pop(cmd_pop), .empty(cmd_empty), .head_word(cmd_head)
   );

   polrs_back u_back (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .cmd_empty(cmd_empty), .cmd_head(cmd_head), .cmd_pop(cmd_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_word(rsp_word)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_word.path_done |-> rsp_word.run_last && !rsp_word.count_clipped)
      else $error("path end word without run_last or with clip flag");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command popped from an empty queue");
`endif
endmodule
`default_nettype wire
